// File: sv/fmtl_pkg.sv
// shared types, constants and helpers for the field map trilinear lookup
package fmtl_pkg;

    localparam int X_CELLS_DEF = 64;
    localparam int Y_CELLS_DEF = 64;
    localparam int Z_CELLS_DEF = 64;

    localparam int POS_W  = 20;
    localparam int IDX_W  = 6;
    localparam int FLD_W  = 18;
    localparam int OUT_W  = 24;
    localparam int OFS_W  = 10;
    localparam int CM_W   = 30;
    localparam int VAL_W  = 26;
    localparam int FRAC_W = 16;
    localparam int TRIG_W = 17;
    localparam int WORD_W = 3 * FLD_W;

    localparam logic [20:0] CM_MUL    = 21'd1677722;
    localparam logic [20:0] CM_BIAS_P = 21'd524290;
    localparam logic [19:0] CM_BIAS_Q = 20'd104858;

    localparam logic [TRIG_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [TRIG_W-1:0] HALF_Q16  = 17'd32768;
    localparam logic [TRIG_W-1:0] COS30_Q16 = 17'd56756;

    typedef enum logic [1:0] {SEC_0, SEC_1, SEC_2} sec_t;

    typedef struct packed {
        logic vld;
        logic qry;
        logic inr;
        logic yneg;
        logic zneg;
        sec_t sec;
        logic sneg;
    } ctl_t;

    typedef struct packed {
        logic [IDX_W-1:0] ix;
        logic [IDX_W-1:0] iy;
        logic [IDX_W-1:0] iz;
        logic [FLD_W-1:0] fx;
        logic [FLD_W-1:0] fy;
        logic [FLD_W-1:0] fz;
    } ld_t;

    function automatic logic [10:0] cm_tail(input logic [2:0] r);
        logic [10:0] t;
        case (r)
            3'd0:    t = 11'd0;
            3'd1:    t = 11'd410;
            3'd2:    t = 11'd819;
            3'd3:    t = 11'd1229;
            3'd4:    t = 11'd1638;
            default: t = 11'd0;
        endcase
        return t;
    endfunction

    function automatic logic [TRIG_W-1:0] cos_of(input sec_t s);
        logic [TRIG_W-1:0] c;
        case (s)
            SEC_1:   c = COS30_Q16;
            SEC_2:   c = HALF_Q16;
            default: c = ONE_Q16;
        endcase
        return c;
    endfunction

    function automatic logic [TRIG_W-1:0] sin_of(input sec_t s);
        logic [TRIG_W-1:0] v;
        case (s)
            SEC_1:   v = HALF_Q16;
            SEC_2:   v = COS30_Q16;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [OUT_W-1:0] sat24(input logic signed [VAL_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > 26'sd8388607) begin
            r = 24'h7FFFFF;
        end else if (v < -26'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: sv/fmtl_lerp.sv
// one two-stage linear interpolation lane
module fmtl_lerp (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [fmtl_pkg::VAL_W-1:0]  a,
    input  logic signed [fmtl_pkg::VAL_W-1:0]  b,
    input  logic [fmtl_pkg::FRAC_W-1:0]        f,
    output logic signed [fmtl_pkg::VAL_W-1:0]  y
);
    localparam int VW = fmtl_pkg::VAL_W;
    localparam int PW = VW + 1 + fmtl_pkg::FRAC_W + 1;

    logic signed [VW:0]   diff;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [VW-1:0] a_reg;
    logic signed [PW-1:0] sum;
    logic signed [VW-1:0] y_reg;

    assign diff      = {b[VW-1], b} - {a[VW-1], a};
    assign prod_next = PW'(diff * $signed({1'b0, f}));

    // a*2^16 + (b-a)*f, rounded
    assign sum = {{2{a_reg[VW-1]}}, a_reg, 16'd0} + prod_reg + PW'(32768);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            a_reg    <= a;
            y_reg    <= sum[16 +: VW];
        end
    end

    assign y = y_reg;
endmodule

// File: sv/fmtl_front.sv
// front end: cm scaling, sector pick, rotation, range check and cell split
module fmtl_front #(
    parameter int X_CELLS = fmtl_pkg::X_CELLS_DEF,
    parameter int Y_CELLS = fmtl_pkg::Y_CELLS_DEF,
    parameter int Z_CELLS = fmtl_pkg::Z_CELLS_DEF,
    parameter int XCW     = $clog2(X_CELLS + 2),
    parameter int YCW     = $clog2(Y_CELLS + 2),
    parameter int ZCW     = $clog2(Z_CELLS + 2)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  fmtl_pkg::ctl_t                     in_ctl,
    input  fmtl_pkg::ld_t                      in_ld,
    input  logic [fmtl_pkg::POS_W-1:0]         pos_x,
    input  logic [fmtl_pkg::POS_W-1:0]         pos_y,
    input  logic [fmtl_pkg::POS_W-1:0]         pos_z,
    input  logic [fmtl_pkg::OFS_W-1:0]         offset,
    output fmtl_pkg::ctl_t                     out_ctl,
    output fmtl_pkg::ld_t                      out_ld,
    output logic [XCW-1:0]                     xi,
    output logic [YCW-1:0]                     yi,
    output logic [ZCW-1:0]                     zi,
    output logic [fmtl_pkg::FRAC_W-1:0]        fx,
    output logic [fmtl_pkg::FRAC_W-1:0]        fy,
    output logic [fmtl_pkg::FRAC_W-1:0]        fz
);
    localparam int CW = fmtl_pkg::CM_W;

    function automatic logic signed [CW-1:0] cm_conv(input logic [41:0] prod,
                                                      input logic [2:0] pn_lo);
        logic [18:0]        q5;
        logic [2:0]         r;
        logic signed [19:0] a;
        q5 = prod[41:23];
        r  = pn_lo - 3'(q5[2:0] * 3'd5);
        a  = {1'b0, q5} - fmtl_pkg::CM_BIAS_Q;
        return CW'({a, 11'd0}) + CW'(fmtl_pkg::cm_tail(r));
    endfunction

    // stage 1: squares and reciprocal products
    fmtl_pkg::ctl_t s1_ctl_reg, s1_ctl_next;
    fmtl_pkg::ld_t  s1_ld_reg;
    logic [39:0]    s1_x2_reg, s1_y2_reg;
    logic [41:0]    s1_px_reg, s1_py_reg, s1_pz_reg;
    logic [2:0]     s1_nx_reg, s1_ny_reg, s1_nz_reg;
    logic [20:0]    pn_x, pn_y, pn_z;
    logic signed [39:0] x2_full, y2_full;

    assign pn_x    = {pos_x[19], pos_x} + fmtl_pkg::CM_BIAS_P;
    assign pn_y    = {pos_y[19], pos_y} + fmtl_pkg::CM_BIAS_P;
    assign pn_z    = {pos_z[19], pos_z} + fmtl_pkg::CM_BIAS_P;
    assign x2_full = $signed(pos_x) * $signed(pos_x);
    assign y2_full = $signed(pos_y) * $signed(pos_y);

    always_comb begin
        s1_ctl_next      = in_ctl;
        s1_ctl_next.inr  = !pos_x[19] && (pos_x != '0);
        s1_ctl_next.sneg = pos_y[19];
        s1_ctl_next.yneg = 1'b0;
        s1_ctl_next.zneg = 1'b0;
        s1_ctl_next.sec  = fmtl_pkg::SEC_0;
    end

    // stage 2: sector and cm coordinates
    fmtl_pkg::ctl_t s2_ctl_reg, s2_ctl_next;
    fmtl_pkg::ld_t  s2_ld_reg;
    logic signed [CW-1:0] s2_xc_reg, s2_yc_reg, s2_zc_reg;
    logic [41:0] x2e, y2e, x3, y3;

    assign x2e = {2'b0, s1_x2_reg};
    assign y2e = {2'b0, s1_y2_reg};
    assign x3  = x2e + {1'b0, s1_x2_reg, 1'b0};
    assign y3  = y2e + {1'b0, s1_y2_reg, 1'b0};

    always_comb begin
        s2_ctl_next = s1_ctl_reg;
        if (!s1_ctl_reg.inr) begin
            s2_ctl_next.sec  = fmtl_pkg::SEC_0;
            s2_ctl_next.sneg = 1'b0;
        end else if (y2e >= x3) begin
            s2_ctl_next.sec = fmtl_pkg::SEC_2;
        end else if (y3 >= x2e) begin
            s2_ctl_next.sec = fmtl_pkg::SEC_1;
        end else begin
            s2_ctl_next.sec = fmtl_pkg::SEC_0;
        end
    end

    // stage 3: rotation products
    localparam int TRIG_S = fmtl_pkg::TRIG_W + 1;
    fmtl_pkg::ctl_t s3_ctl_reg;
    fmtl_pkg::ld_t  s3_ld_reg;
    logic signed [47:0] s3_cx_reg, s3_sy_reg, s3_cy_reg, s3_sx_reg;
    logic signed [CW-1:0] s3_zc_reg;
    logic signed [TRIG_S-1:0] cs, ss;

    assign cs = {1'b0, fmtl_pkg::cos_of(s2_ctl_reg.sec)};
    assign ss = {1'b0, fmtl_pkg::sin_of(s2_ctl_reg.sec)};

    // stage 4: rotated coordinates
    fmtl_pkg::ctl_t s4_ctl_reg;
    fmtl_pkg::ld_t  s4_ld_reg;
    logic signed [31:0]   s4_xr_reg, s4_yr_reg;
    logic signed [CW-1:0] s4_zc_reg;
    logic signed [47:0]   xr_sum, yr_sum;

    assign xr_sum = (s3_ctl_reg.sneg ? s3_cx_reg - s3_sy_reg : s3_cx_reg + s3_sy_reg)
                    + 48'sd32768;
    assign yr_sum = (s3_ctl_reg.sneg ? s3_cy_reg + s3_sx_reg : s3_cy_reg - s3_sx_reg)
                    + 48'sd32768;

    // stage 5: range check and cell split
    fmtl_pkg::ctl_t s5_ctl_reg, s5_ctl_next;
    fmtl_pkg::ld_t  s5_ld_reg;
    logic [XCW-1:0] s5_xi_reg;
    logic [YCW-1:0] s5_yi_reg;
    logic [ZCW-1:0] s5_zi_reg;
    logic [fmtl_pkg::FRAC_W-1:0] s5_fx_reg, s5_fy_reg, s5_fz_reg;
    logic [31:0] ay, az, lo_v, hi_v, xo;

    assign ay   = s4_yr_reg[31] ? 32'(-s4_yr_reg) : 32'(s4_yr_reg);
    assign az   = s4_zc_reg[CW-1] ? 32'(-s4_zc_reg) : 32'(s4_zc_reg);
    assign lo_v = 32'(offset) << 16;
    assign hi_v = (32'(offset) + 32'(X_CELLS)) << 16;
    assign xo   = 32'(s4_xr_reg) - lo_v;

    always_comb begin
        s5_ctl_next      = s4_ctl_reg;
        s5_ctl_next.inr  = s4_ctl_reg.inr
                           && ($signed(s4_xr_reg) >= $signed(lo_v))
                           && ($signed(s4_xr_reg) <= $signed(hi_v))
                           && (ay <= (32'(Y_CELLS) << 16))
                           && (az <= (32'(Z_CELLS) << 16));
        s5_ctl_next.yneg = s4_yr_reg[31];
        s5_ctl_next.zneg = s4_zc_reg[CW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
        end else if (en) begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s2_ctl_next;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
            s5_ctl_reg <= s5_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ld_reg <= in_ld;
            s1_x2_reg <= x2_full[39:0];
            s1_y2_reg <= y2_full[39:0];
            s1_px_reg <= 42'(pn_x) * 42'(fmtl_pkg::CM_MUL);
            s1_py_reg <= 42'(pn_y) * 42'(fmtl_pkg::CM_MUL);
            s1_pz_reg <= 42'(pn_z) * 42'(fmtl_pkg::CM_MUL);
            s1_nx_reg <= pn_x[2:0];
            s1_ny_reg <= pn_y[2:0];
            s1_nz_reg <= pn_z[2:0];

            s2_ld_reg <= s1_ld_reg;
            s2_xc_reg <= cm_conv(s1_px_reg, s1_nx_reg);
            s2_yc_reg <= cm_conv(s1_py_reg, s1_ny_reg);
            s2_zc_reg <= cm_conv(s1_pz_reg, s1_nz_reg);

            s3_ld_reg <= s2_ld_reg;
            s3_cx_reg <= 48'(cs * s2_xc_reg);
            s3_sy_reg <= 48'(ss * s2_yc_reg);
            s3_cy_reg <= 48'(cs * s2_yc_reg);
            s3_sx_reg <= 48'(ss * s2_xc_reg);
            s3_zc_reg <= s2_zc_reg;

            s4_ld_reg <= s3_ld_reg;
            s4_xr_reg <= xr_sum[47:16];
            s4_yr_reg <= yr_sum[47:16];
            s4_zc_reg <= s3_zc_reg;

            s5_ld_reg <= s4_ld_reg;
            s5_xi_reg <= xo[16 +: XCW];
            s5_yi_reg <= ay[16 +: YCW];
            s5_zi_reg <= az[16 +: ZCW];
            s5_fx_reg <= xo[15:0];
            s5_fy_reg <= ay[15:0];
            s5_fz_reg <= az[15:0];
        end
    end

    assign out_ctl = s5_ctl_reg;
    assign out_ld  = s5_ld_reg;
    assign xi      = s5_xi_reg;
    assign yi      = s5_yi_reg;
    assign zi      = s5_zi_reg;
    assign fx      = s5_fx_reg;
    assign fy      = s5_fy_reg;
    assign fz      = s5_fz_reg;
endmodule

// File: sv/fmtl_grid.sv
// grid store in eight parity banks, one corner read per bank per beat
module fmtl_grid #(
    parameter int X_CELLS = fmtl_pkg::X_CELLS_DEF,
    parameter int Y_CELLS = fmtl_pkg::Y_CELLS_DEF,
    parameter int Z_CELLS = fmtl_pkg::Z_CELLS_DEF,
    parameter int XCW     = $clog2(X_CELLS + 2),
    parameter int YCW     = $clog2(Y_CELLS + 2),
    parameter int ZCW     = $clog2(Z_CELLS + 2)
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  fmtl_pkg::ctl_t                         in_ctl,
    input  fmtl_pkg::ld_t                          in_ld,
    input  logic [XCW-1:0]                         xi,
    input  logic [YCW-1:0]                         yi,
    input  logic [ZCW-1:0]                         zi,
    input  logic [fmtl_pkg::FRAC_W-1:0]            fx,
    input  logic [fmtl_pkg::FRAC_W-1:0]            fy,
    input  logic [fmtl_pkg::FRAC_W-1:0]            fz,
    output fmtl_pkg::ctl_t                         out_ctl,
    output logic [fmtl_pkg::FRAC_W-1:0]            out_fx,
    output logic [fmtl_pkg::FRAC_W-1:0]            out_fy,
    output logic [fmtl_pkg::FRAC_W-1:0]            out_fz,
    output logic [2:0][7:0][fmtl_pkg::VAL_W-1:0]   corners
);
    localparam int HXW = (X_CELLS > 3) ? $clog2((X_CELLS + 1) / 2) : 1;
    localparam int HYW = (Y_CELLS > 3) ? $clog2((Y_CELLS + 1) / 2) : 1;
    localparam int HZW = (Z_CELLS > 3) ? $clog2((Z_CELLS + 1) / 2) : 1;
    localparam int AW  = HXW + HYW + HZW;
    localparam int WW  = fmtl_pkg::WORD_W;
    localparam int FW  = fmtl_pkg::FLD_W;

    logic          ld_ok, ld_we;
    logic [2:0]    ld_bank;
    logic [AW-1:0] ld_addr;
    logic [WW-1:0] ld_word;

    assign ld_ok   = (9'(in_ld.ix) < 9'(X_CELLS)) && (9'(in_ld.iy) < 9'(Y_CELLS))
                     && (9'(in_ld.iz) < 9'(Z_CELLS));
    assign ld_we   = in_ctl.vld && !in_ctl.qry && ld_ok;
    assign ld_bank = {in_ld.ix[0], in_ld.iy[0], in_ld.iz[0]};
    assign ld_addr = {HXW'(in_ld.ix >> 1), HYW'(in_ld.iy >> 1), HZW'(in_ld.iz >> 1)};
    assign ld_word = {in_ld.fz, in_ld.fy, in_ld.fx};

    logic [XCW-1:0] xsel [2];
    logic [YCW-1:0] ysel [2];
    logic [ZCW-1:0] zsel [2];
    logic [7:0]     ing_next;

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            xsel[p] = (xi[0] == 1'(p)) ? xi : xi + XCW'(1);
            ysel[p] = (yi[0] == 1'(p)) ? yi : yi + YCW'(1);
            zsel[p] = (zi[0] == 1'(p)) ? zi : zi + ZCW'(1);
        end
        for (int c = 0; c < 8; c++) begin
            ing_next[c] = ((xi + XCW'(c >> 2)) < XCW'(X_CELLS))
                          && ((yi + YCW'((c >> 1) & 1)) < YCW'(Y_CELLS))
                          && ((zi + ZCW'(c & 1)) < ZCW'(Z_CELLS));
        end
    end

    logic [7:0][WW-1:0] rd_reg;

    for (genvar b = 0; b < 8; b++) begin : g_bank
        logic [WW-1:0] mem [2**AW];
        logic [AW-1:0] raddr;
        logic [XCW-1:0] bx;
        logic [YCW-1:0] by;
        logic [ZCW-1:0] bz;

        assign bx    = xsel[(b >> 2) & 1] >> 1;
        assign by    = ysel[(b >> 1) & 1] >> 1;
        assign bz    = zsel[b & 1] >> 1;
        assign raddr = {bx[HXW-1:0], by[HYW-1:0], bz[HZW-1:0]};

        always_ff @(posedge aclk) begin
            if (en) begin
                if (ld_we && ld_bank == 3'(b)) begin
                    mem[ld_addr] <= ld_word;
                end
                rd_reg[b] <= mem[raddr];
            end
        end
    end

    fmtl_pkg::ctl_t ctl_reg;
    logic [7:0]     ing_reg;
    logic [2:0]     par_reg;
    logic [fmtl_pkg::FRAC_W-1:0] fx_reg, fy_reg, fz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ing_reg <= ing_next;
            par_reg <= {xi[0], yi[0], zi[0]};
            fx_reg  <= fx;
            fy_reg  <= fy;
            fz_reg  <= fz;
        end
    end

    // corner c sits in bank c xor the base parities
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            for (int k = 0; k < 3; k++) begin
                corners[k][c] = ing_reg[c]
                    ? {rd_reg[3'(c) ^ par_reg][k*FW +: FW], 8'd0}
                    : '0;
            end
        end
    end

    assign out_ctl = ctl_reg;
    assign out_fx  = fx_reg;
    assign out_fy  = fy_reg;
    assign out_fz  = fz_reg;
endmodule

// File: sv/fmtl_interp.sv
// trilinear interpolation: z, then y, then x, two stages each
module fmtl_interp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  fmtl_pkg::ctl_t                         in_ctl,
    input  logic [fmtl_pkg::FRAC_W-1:0]            fx,
    input  logic [fmtl_pkg::FRAC_W-1:0]            fy,
    input  logic [fmtl_pkg::FRAC_W-1:0]            fz,
    input  logic [2:0][7:0][fmtl_pkg::VAL_W-1:0]   corners,
    output fmtl_pkg::ctl_t                         out_ctl,
    output logic [2:0][fmtl_pkg::VAL_W-1:0]        fld
);
    localparam int FRW = fmtl_pkg::FRAC_W;
    localparam int VW  = fmtl_pkg::VAL_W;

    fmtl_pkg::ctl_t ctl_reg [6];
    logic [FRW-1:0] fy_reg [2];
    logic [FRW-1:0] fx_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                ctl_reg[i] <= '0;
            end
        end else if (en) begin
            ctl_reg[0] <= in_ctl;
            for (int i = 1; i < 6; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fy_reg[0] <= fy;
            fy_reg[1] <= fy_reg[0];
            fx_reg[0] <= fx;
            for (int i = 1; i < 4; i++) begin
                fx_reg[i] <= fx_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_comp
        logic signed [VW-1:0] zl [4];
        logic signed [VW-1:0] yl [2];

        for (genvar j = 0; j < 4; j++) begin : g_z
            fmtl_lerp u_lz (
                .aclk (aclk),
                .en   (en),
                .a    (corners[k][2*j]),
                .b    (corners[k][2*j+1]),
                .f    (fz),
                .y    (zl[j])
            );
        end

        for (genvar j = 0; j < 2; j++) begin : g_y
            fmtl_lerp u_ly (
                .aclk (aclk),
                .en   (en),
                .a    (zl[2*j]),
                .b    (zl[2*j+1]),
                .f    (fy_reg[1]),
                .y    (yl[j])
            );
        end

        fmtl_lerp u_lx (
            .aclk (aclk),
            .en   (en),
            .a    (yl[0]),
            .b    (yl[1]),
            .f    (fx_reg[3]),
            .y    (fld[k])
        );
    end

    assign out_ctl = ctl_reg[5];
endmodule

// File: sv/fmtl_back.sv
// symmetry, rotation back into the sector, rounding and saturation
module fmtl_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  fmtl_pkg::ctl_t                    in_ctl,
    input  logic [2:0][fmtl_pkg::VAL_W-1:0]   fld,
    output fmtl_pkg::ctl_t                    out_ctl,
    output logic [fmtl_pkg::OUT_W-1:0]        field_x,
    output logic [fmtl_pkg::OUT_W-1:0]        field_y,
    output logic [fmtl_pkg::OUT_W-1:0]        field_z
);
    localparam int VW = fmtl_pkg::VAL_W;
    localparam int PW = VW + 1 + fmtl_pkg::TRIG_W + 1;

    logic signed [VW:0]   bxn, byv, bzn;
    logic signed [fmtl_pkg::TRIG_W:0] cs, ss;

    assign bxn = in_ctl.yneg ? -{fld[0][VW-1], fld[0]} : {fld[0][VW-1], fld[0]};
    assign byv = {fld[1][VW-1], fld[1]};
    assign bzn = (in_ctl.yneg ^ in_ctl.zneg) ? -{fld[2][VW-1], fld[2]}
                                              : {fld[2][VW-1], fld[2]};
    assign cs  = {1'b0, fmtl_pkg::cos_of(in_ctl.sec)};
    assign ss  = {1'b0, fmtl_pkg::sin_of(in_ctl.sec)};

    fmtl_pkg::ctl_t     ctl_reg;
    logic signed [PW-1:0] cx_reg, sy_reg, sx_reg, cy_reg;
    logic signed [VW:0]   bz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg <= PW'(cs * bxn);
            sy_reg <= PW'(ss * byv);
            sx_reg <= PW'(ss * bxn);
            cy_reg <= PW'(cs * byv);
            bz_reg <= bzn;
        end
    end

    logic signed [PW:0]   ox_sum, oy_sum;
    logic signed [VW:0]   oz_sum;

    assign ox_sum = (ctl_reg.sneg ? (PW+1)'(cx_reg) + sy_reg : (PW+1)'(cx_reg) - sy_reg)
                    + (PW+1)'(524288);
    assign oy_sum = (ctl_reg.sneg ? (PW+1)'(cy_reg) - sx_reg : (PW+1)'(sx_reg) + cy_reg)
                    + (PW+1)'(524288);
    assign oz_sum = bz_reg + (VW+1)'(8);

    assign out_ctl = ctl_reg;
    assign field_x = fmtl_pkg::sat24(ox_sum[20 +: VW]);
    assign field_y = fmtl_pkg::sat24(oy_sum[20 +: VW]);
    assign field_z = {oz_sum[VW], oz_sum[VW:4]};
endmodule

// File: sv/field_map_trilinear_lookup_top.sv
// top level of the trilinear field map lookup
// Takes one beat per clock while the output is not held, loads and queries
// alike, and presents one result beat per query; loads give no result. All
// stages advance together, so a held output beat stalls the whole pipe. The
// grid sits in eight banks split by the parity of each index, so the eight
// corners of a cell are read together, one per bank port; a load writes at
// the same pipe stage where queries read, which keeps loads and queries in
// beat order. The grid needs no clearing after reset: every entry must be
// loaded before any query touches it. The offset register may only be
// written while no beat is in flight.
module field_map_trilinear_lookup_top #(
    parameter int X_CELLS = fmtl_pkg::X_CELLS_DEF,
    parameter int Y_CELLS = fmtl_pkg::Y_CELLS_DEF,
    parameter int Z_CELLS = fmtl_pkg::Z_CELLS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [9:0]    cfg_wdata,       // grid_x_offset
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,    // pos_x, pos_y, pos_z, load_ix, load_iy,
                                           // load_iz, load_fx, load_fy, load_fz
    input  logic          s_axis_tuser,    // action
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [71:0]   m_axis_tdata,    // field_x, field_y, field_z
    output logic          m_axis_tuser     // in_range
);
    localparam int XCW = $clog2(X_CELLS + 2);
    localparam int YCW = $clog2(Y_CELLS + 2);
    localparam int ZCW = $clog2(Z_CELLS + 2);
    localparam int FRW = fmtl_pkg::FRAC_W;
    localparam int VW  = fmtl_pkg::VAL_W;
    localparam int OW  = fmtl_pkg::OUT_W;

    logic [fmtl_pkg::OFS_W-1:0] offset_reg;
    logic adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (cfg_we) begin
            offset_reg <= cfg_wdata;
        end
    end

    fmtl_pkg::ctl_t in_ctl;
    fmtl_pkg::ld_t  in_ld;

    always_comb begin
        in_ctl     = '0;
        in_ctl.vld = s_axis_tvalid && adv;
        in_ctl.qry = s_axis_tuser;
        in_ld.ix   = s_axis_tdata[65:60];
        in_ld.iy   = s_axis_tdata[71:66];
        in_ld.iz   = s_axis_tdata[77:72];
        in_ld.fx   = s_axis_tdata[95:78];
        in_ld.fy   = s_axis_tdata[113:96];
        in_ld.fz   = s_axis_tdata[131:114];
    end

    fmtl_pkg::ctl_t fr_ctl, gr_ctl, ip_ctl, bk_ctl;
    fmtl_pkg::ld_t  fr_ld;
    logic [XCW-1:0] fr_xi;
    logic [YCW-1:0] fr_yi;
    logic [ZCW-1:0] fr_zi;
    logic [FRW-1:0] fr_fx, fr_fy, fr_fz, gr_fx, gr_fy, gr_fz;
    logic [2:0][7:0][VW-1:0] gr_corners;
    logic [2:0][VW-1:0]      ip_fld;
    logic [OW-1:0]  bk_x, bk_y, bk_z;

    fmtl_front #(
        .X_CELLS (X_CELLS), .Y_CELLS (Y_CELLS), .Z_CELLS (Z_CELLS),
        .XCW (XCW), .YCW (YCW), .ZCW (ZCW)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_ctl  (in_ctl),
        .in_ld   (in_ld),
        .pos_x   (s_axis_tdata[19:0]),
        .pos_y   (s_axis_tdata[39:20]),
        .pos_z   (s_axis_tdata[59:40]),
        .offset  (offset_reg),
        .out_ctl (fr_ctl),
        .out_ld  (fr_ld),
        .xi      (fr_xi),
        .yi      (fr_yi),
        .zi      (fr_zi),
        .fx      (fr_fx),
        .fy      (fr_fy),
        .fz      (fr_fz)
    );

    fmtl_grid #(
        .X_CELLS (X_CELLS), .Y_CELLS (Y_CELLS), .Z_CELLS (Z_CELLS),
        .XCW (XCW), .YCW (YCW), .ZCW (ZCW)
    ) u_grid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_ctl  (fr_ctl),
        .in_ld   (fr_ld),
        .xi      (fr_xi),
        .yi      (fr_yi),
        .zi      (fr_zi),
        .fx      (fr_fx),
        .fy      (fr_fy),
        .fz      (fr_fz),
        .out_ctl (gr_ctl),
        .out_fx  (gr_fx),
        .out_fy  (gr_fy),
        .out_fz  (gr_fz),
        .corners (gr_corners)
    );

    fmtl_interp u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_ctl  (gr_ctl),
        .fx      (gr_fx),
        .fy      (gr_fy),
        .fz      (gr_fz),
        .corners (gr_corners),
        .out_ctl (ip_ctl),
        .fld     (ip_fld)
    );

    fmtl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_ctl  (ip_ctl),
        .fld     (ip_fld),
        .out_ctl (bk_ctl),
        .field_x (bk_x),
        .field_y (bk_y),
        .field_z (bk_z)
    );

    logic          m_valid_reg;
    logic          m_inr_reg;
    logic [OW-1:0] m_fx_reg, m_fy_reg, m_fz_reg;

    assign adv = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= bk_ctl.vld && bk_ctl.qry;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_inr_reg <= bk_ctl.inr;
            m_fx_reg  <= bk_ctl.inr ? bk_x : '0;
            m_fy_reg  <= bk_ctl.inr ? bk_y : '0;
            m_fz_reg  <= bk_ctl.inr ? bk_z : '0;
        end
    end

    assign s_axis_tready = adv;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_fz_reg, m_fy_reg, m_fx_reg};
    assign m_axis_tuser  = m_inr_reg;

    // out of range beats carry a zero field
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_inr_reg |-> m_fx_reg == '0 && m_fy_reg == '0 && m_fz_reg == '0)
        else $error("nonzero field on out of range beat");

    // held result blocks the input side
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while result held");

    // z field never exceeds the interpolated grid range
    a_z_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $signed(m_fz_reg) <= 24'sd2097152
                        && $signed(m_fz_reg) >= -24'sd2097152)
        else $error("z field beyond grid range");

    // a load never makes a result beat
    a_no_load_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && bk_ctl.vld && !bk_ctl.qry |=> !m_valid_reg)
        else $error("result beat from a load");
endmodule
